/* rtl/hdrc_pkg.sv */
package hdrc_pkg;

    localparam int DEVICES = 16;
    localparam int AUDIT_CAPACITY = 256;
    localparam int DEV_W = $clog2(DEVICES);
    localparam int AUD_W = $clog2(AUDIT_CAPACITY + 1);

    typedef enum logic [3:0] {
        MD_REQUEST  = 4'd0,
        MD_DETACH   = 4'd1,
        MD_CONF_DET = 4'd2,
        MD_CONF_ATT = 4'd3,
        MD_LOST     = 4'd4,
        MD_CLEAR    = 4'd5,
        MD_SWEEP    = 4'd6,
        MD_SNAPSHOT = 4'd7,
        MD_AUD_CLR  = 4'd8
    } mode_t;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_STALE = 3'd2;
    localparam logic [2:0] ST_WRONG = 3'd3;
    localparam logic [2:0] ST_CAPACITY = 3'd4;
    localparam logic [2:0] ST_EXHAUSTED = 3'd5;

    localparam logic [2:0] RS_UNASSIGNED = 3'd0;
    localparam logic [2:0] RS_DETACHING = 3'd1;
    localparam logic [2:0] RS_ATTACHING = 3'd2;
    localparam logic [2:0] RS_ACTIVE = 3'd3;
    localparam logic [2:0] RS_FAULT = 3'd4;

    localparam logic [2:0] AC_REQUESTED = 3'd0;
    localparam logic [2:0] AC_DETACH_REQ = 3'd1;
    localparam logic [2:0] AC_ATTACH_REQ = 3'd2;
    localparam logic [2:0] AC_DETACHED = 3'd3;
    localparam logic [2:0] AC_ATTACHED = 3'd4;
    localparam logic [2:0] AC_LOST = 3'd5;
    localparam logic [2:0] AC_CLEARED = 3'd6;
    localparam logic [2:0] AC_TIMEOUT = 3'd7;

    localparam logic [0:0] CFG_ATTACH = 1'd0;
    localparam logic [0:0] CFG_DETACH = 1'd1;

    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] now_tick;
        logic [15:0] host_id;
        logic [15:0] device_id;
        logic [63:0] epoch_tag;
    } cmd_t;

    typedef struct packed {
        logic        last;
        logic [2:0]  status;
        logic [63:0] time_value;
        logic [63:0] epoch_value;
        logic [15:0] host_value;
        logic [15:0] pending_value;
        logic [15:0] device_value;
        logic [2:0]  action;
        logic [2:0]  route_state;
        logic [7:0]  sequence_res;
        logic [1:0]  host_flags;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;      // capture command
        logic             scan_clr;  // reset scan index
        logic             scan_step; // host-busy scan one route
        logic             sweep_step;// sweep one route
        logic             exec;      // apply single-route command
        logic             emit2;     // emit second record
        logic             status;    // emit status word
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
        logic rec2_pend;
        logic sweep_stop;
    } dp_sts_t;

endpackage

/* rtl/hdrc_if.sv */
interface hdrc_cmd_if;
    import hdrc_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hdrc_res_if;
    import hdrc_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/hdrc_ctrl.sv */
module hdrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        in_mode,
    input  hdrc_pkg::dp_sts_t sts,
    output hdrc_pkg::dp_cmd_t cmd
);
    import hdrc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_REC2  = 6'b001000,
        S_SWEEP = 6'b010000,
        S_STAT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    if (in_mode == MD_SWEEP)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    cmd.exec = 1'b1;
                    state_next = S_REC2;
                end
            end
            S_REC2:
            begin
                if (!sts.out_busy)
                begin
                    if (sts.rec2_pend)
                    begin
                        cmd.emit2 = 1'b1;
                    end
                    state_next = S_STAT;
                end
            end
            S_SWEEP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.sweep_step = 1'b1;
                    if (sts.scan_done || sts.sweep_stop)
                    begin
                        state_next = S_STAT;
                    end
                end
            end
            S_STAT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.status = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/hdrc_dp.sv */
module hdrc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  hdrc_pkg::cmd_t    in_data,
    input  logic [31:0]       attach_timeout,
    input  logic [31:0]       detach_timeout,
    input  hdrc_pkg::dp_cmd_t cmd,
    output hdrc_pkg::dp_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output hdrc_pkg::res_t    out_data
);
    import hdrc_pkg::*;

    // route table
    logic [63:0] epoch_reg [DEVICES];
    logic [2:0]  rmode_reg [DEVICES];
    logic [15:0] ahost_reg [DEVICES];
    logic [15:0] phost_reg [DEVICES];
    logic [DEVICES-1:0] aval_reg;
    logic [DEVICES-1:0] pval_reg;
    logic [63:0] dline_reg [DEVICES];
    logic [AUD_W-1:0] used_reg;

    cmd_t c_reg;
    logic [DEV_W:0] idx_reg;
    logic busy_reg;
    logic rec2_reg;
    res_t rec2_data_reg;
    logic [2:0] st_reg;
    logic out_valid_reg;
    res_t out_reg;

    logic dev_ok;
    logic [DEV_W-1:0] d;
    logic [DEV_W-1:0] si;
    logic [63:0] ep;
    logic [2:0] rm;
    logic [AUD_W-1:0] free;
    logic ep_max;
    logic [63:0] tdiff;

    assign dev_ok = (c_reg.device_id < 16'(DEVICES));
    assign d = dev_ok ? c_reg.device_id[DEV_W-1:0] : '0;
    assign si = idx_reg[DEV_W-1:0];
    assign ep = epoch_reg[d];
    assign rm = rmode_reg[d];
    assign free = AUD_W'(AUDIT_CAPACITY) - used_reg;
    assign ep_max = (ep == 64'hFFFF_FFFF_FFFF_FFFF);
    assign tdiff = c_reg.now_tick - dline_reg[si];

    assign sts.scan_done = (idx_reg == (DEV_W+1)'(DEVICES - 1));
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign sts.rec2_pend = rec2_reg;
    assign sts.sweep_stop = 1'b0;

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    function automatic res_t rec(input logic [63:0] t, input logic [63:0] e,
                                 input logic [15:0] h, input logic [15:0] dv,
                                 input logic [2:0] a, input logic [2:0] s,
                                 input logic [7:0] q);
        res_t r;
        r = '0;
        r.time_value = t;
        r.epoch_value = e;
        r.host_value = h;
        r.device_value = dv;
        r.action = a;
        r.route_state = s;
        r.sequence_res = q;
        return r;
    endfunction

    logic [15:0] dv16;
    assign dv16 = 16'(d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEVICES; i++)
            begin
                epoch_reg[i] <= '0;
                rmode_reg[i] <= RS_UNASSIGNED;
                ahost_reg[i] <= '0;
                phost_reg[i] <= '0;
                dline_reg[i] <= '0;
            end
            aval_reg <= '0;
            pval_reg <= '0;
            used_reg <= '0;
            idx_reg <= '0;
            busy_reg <= 1'b0;
            rec2_reg <= 1'b0;
            st_reg <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                c_reg <= in_data;
                st_reg <= ST_OK;
                rec2_reg <= 1'b0;
            end
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
                busy_reg <= 1'b0;
            end
            // host exclusivity scan, one route a cycle
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (si != d && ((aval_reg[si] && ahost_reg[si] == c_reg.host_id)
                    || (pval_reg[si] && phost_reg[si] == c_reg.host_id)))
                begin
                    busy_reg <= 1'b1;
                end
            end
            // timeout sweep, one route a cycle while the output is not stalled
            if (cmd.sweep_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (st_reg == ST_OK
                    && (rmode_reg[si] == RS_DETACHING || rmode_reg[si] == RS_ATTACHING)
                    && !tdiff[63])
                begin
                    if (free == '0)
                    begin
                        st_reg <= ST_CAPACITY;
                    end
                    else
                    begin
                        aval_reg[si] <= 1'b0;
                        pval_reg[si] <= 1'b0;
                        rmode_reg[si] <= RS_FAULT;
                        dline_reg[si] <= '0;
                        used_reg <= used_reg + 1'b1;
                        out_valid_reg <= 1'b1;
                        out_reg <= rec(c_reg.now_tick, epoch_reg[si], 16'h0, 16'(si),
                                       AC_TIMEOUT, RS_FAULT, used_reg[7:0]);
                    end
                end
            end
            // single-route commands
            if (cmd.exec)
            begin
                unique case (c_reg.mode)
                    MD_REQUEST:
                    begin
                        if (c_reg.host_id == '0 || !dev_ok)
                            st_reg <= ST_INVALID;
                        else if (rm == RS_ACTIVE && aval_reg[d]
                                 && ahost_reg[d] == c_reg.host_id)
                            st_reg <= ST_OK;
                        else if (rm != RS_UNASSIGNED && rm != RS_ACTIVE)
                            st_reg <= ST_WRONG;
                        else if (busy_reg)
                            st_reg <= ST_WRONG;
                        else if (free < AUD_W'(2))
                            st_reg <= ST_CAPACITY;
                        else if (ep_max)
                            st_reg <= ST_EXHAUSTED;
                        else
                        begin
                            epoch_reg[d] <= ep + 1'b1;
                            phost_reg[d] <= c_reg.host_id;
                            pval_reg[d] <= 1'b1;
                            used_reg <= used_reg + AUD_W'(2);
                            out_valid_reg <= 1'b1;
                            out_reg <= rec(c_reg.now_tick, ep + 1'b1, c_reg.host_id, dv16,
                                           AC_REQUESTED, rm, used_reg[7:0]);
                            rec2_reg <= 1'b1;
                            if (rm == RS_ACTIVE)
                            begin
                                rmode_reg[d] <= RS_DETACHING;
                                dline_reg[d] <= c_reg.now_tick + 64'(detach_timeout);
                                rec2_data_reg <= rec(c_reg.now_tick, ep + 1'b1,
                                    ahost_reg[d], dv16, AC_DETACH_REQ, RS_DETACHING,
                                    used_reg[7:0] + 8'd1);
                            end
                            else
                            begin
                                rmode_reg[d] <= RS_ATTACHING;
                                dline_reg[d] <= c_reg.now_tick + 64'(attach_timeout);
                                rec2_data_reg <= rec(c_reg.now_tick, ep + 1'b1,
                                    c_reg.host_id, dv16, AC_ATTACH_REQ, RS_ATTACHING,
                                    used_reg[7:0] + 8'd1);
                            end
                        end
                    end
                    MD_DETACH:
                    begin
                        if (!dev_ok)
                            st_reg <= ST_INVALID;
                        else if (rm == RS_UNASSIGNED)
                            st_reg <= ST_OK;
                        else if (rm != RS_ACTIVE)
                            st_reg <= ST_WRONG;
                        else if (free == '0)
                            st_reg <= ST_CAPACITY;
                        else if (ep_max)
                            st_reg <= ST_EXHAUSTED;
                        else
                        begin
                            epoch_reg[d] <= ep + 1'b1;
                            pval_reg[d] <= 1'b0;
                            rmode_reg[d] <= RS_DETACHING;
                            dline_reg[d] <= c_reg.now_tick + 64'(detach_timeout);
                            used_reg <= used_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            out_reg <= rec(c_reg.now_tick, ep + 1'b1, ahost_reg[d], dv16,
                                           AC_DETACH_REQ, RS_DETACHING, used_reg[7:0]);
                        end
                    end
                    MD_CONF_DET:
                    begin
                        if (!dev_ok)
                            st_reg <= ST_INVALID;
                        else if (c_reg.epoch_tag != ep)
                            st_reg <= ST_STALE;
                        else if (rm != RS_DETACHING)
                            st_reg <= ST_WRONG;
                        else if (free < (pval_reg[d] ? AUD_W'(2) : AUD_W'(1)))
                            st_reg <= ST_CAPACITY;
                        else
                        begin
                            aval_reg[d] <= 1'b0;
                            out_valid_reg <= 1'b1;
                            out_reg <= rec(c_reg.now_tick, ep, ahost_reg[d], dv16,
                                           AC_DETACHED, RS_DETACHING, used_reg[7:0]);
                            if (pval_reg[d])
                            begin
                                used_reg <= used_reg + AUD_W'(2);
                                rmode_reg[d] <= RS_ATTACHING;
                                dline_reg[d] <= c_reg.now_tick + 64'(attach_timeout);
                                rec2_reg <= 1'b1;
                                rec2_data_reg <= rec(c_reg.now_tick, ep, phost_reg[d], dv16,
                                    AC_ATTACH_REQ, RS_ATTACHING, used_reg[7:0] + 8'd1);
                            end
                            else
                            begin
                                used_reg <= used_reg + 1'b1;
                                rmode_reg[d] <= RS_UNASSIGNED;
                                dline_reg[d] <= '0;
                            end
                        end
                    end
                    MD_CONF_ATT:
                    begin
                        if (c_reg.host_id == '0 || !dev_ok)
                            st_reg <= ST_INVALID;
                        else if (c_reg.epoch_tag != ep)
                            st_reg <= ST_STALE;
                        else if (rm != RS_ATTACHING || !pval_reg[d]
                                 || phost_reg[d] != c_reg.host_id)
                            st_reg <= ST_WRONG;
                        else if (free == '0)
                            st_reg <= ST_CAPACITY;
                        else
                        begin
                            ahost_reg[d] <= c_reg.host_id;
                            aval_reg[d] <= 1'b1;
                            pval_reg[d] <= 1'b0;
                            rmode_reg[d] <= RS_ACTIVE;
                            dline_reg[d] <= '0;
                            used_reg <= used_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            out_reg <= rec(c_reg.now_tick, ep, c_reg.host_id, dv16,
                                           AC_ATTACHED, RS_ACTIVE, used_reg[7:0]);
                        end
                    end
                    MD_LOST:
                    begin
                        if (!dev_ok)
                            st_reg <= ST_INVALID;
                        else if (c_reg.epoch_tag != ep)
                            st_reg <= ST_STALE;
                        else if (rm == RS_UNASSIGNED)
                            st_reg <= ST_WRONG;
                        else if (free == '0)
                            st_reg <= ST_CAPACITY;
                        else
                        begin
                            aval_reg[d] <= 1'b0;
                            pval_reg[d] <= 1'b0;
                            rmode_reg[d] <= RS_FAULT;
                            dline_reg[d] <= '0;
                            used_reg <= used_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            out_reg <= rec(c_reg.now_tick, ep, 16'h0, dv16,
                                           AC_LOST, RS_FAULT, used_reg[7:0]);
                        end
                    end
                    MD_CLEAR:
                    begin
                        if (!dev_ok)
                            st_reg <= ST_INVALID;
                        else if (rm != RS_FAULT)
                            st_reg <= ST_WRONG;
                        else if (free == '0)
                            st_reg <= ST_CAPACITY;
                        else if (ep_max)
                            st_reg <= ST_EXHAUSTED;
                        else
                        begin
                            epoch_reg[d] <= ep + 1'b1;
                            rmode_reg[d] <= RS_UNASSIGNED;
                            dline_reg[d] <= '0;
                            used_reg <= used_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            out_reg <= rec(c_reg.now_tick, ep + 1'b1, 16'h0, dv16,
                                           AC_CLEARED, RS_UNASSIGNED, used_reg[7:0]);
                        end
                    end
                    MD_SNAPSHOT, MD_SWEEP:
                    begin
                        st_reg <= ST_OK;
                    end
                    MD_AUD_CLR:
                    begin
                        used_reg <= '0;
                    end
                    default:
                    begin
                        st_reg <= ST_INVALID;
                    end
                endcase
            end
            if (cmd.emit2)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= rec2_data_reg;
            end
            // final status word, snapshot carries route contents
            if (cmd.status)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= '0;
                out_reg.last <= 1'b1;
                out_reg.status <= st_reg;
                if (c_reg.mode == MD_SNAPSHOT)
                begin
                    out_reg.device_value <= c_reg.device_id;
                    if (!dev_ok)
                    begin
                        out_reg.status <= ST_INVALID;
                        out_reg.route_state <= RS_FAULT;
                    end
                    else
                    begin
                        out_reg.status <= ST_OK;
                        out_reg.time_value <= dline_reg[d];
                        out_reg.epoch_value <= ep;
                        out_reg.host_value <= ahost_reg[d];
                        out_reg.pending_value <= phost_reg[d];
                        out_reg.route_state <= rm;
                        out_reg.host_flags <= {pval_reg[d], aval_reg[d]};
                    end
                end
            end
        end
    end

endmodule

/* rtl/host_device_route_controller.sv */
// channel  dir  payload                          handshake
// cmd_in   in   mode, now_tick, ids, epoch_tag   valid/ready
// res_out  out  audit records then status word   valid/ready
// cfg      in   wr_en, wr_index, wr_data         write enable
// each command: accept, a host check over every other route in the table,
// then first record, second record when one is pending, and status word
// a sweep: accept, a pass over the routes, one record at most per route, then status
// reset clears all routes and the audit count at once; no clearing pass
// a stalled result holds the sequencer; input ready only while idle
module host_device_route_controller (
    input  logic        clk,
    input  logic        rst_n,
    hdrc_cmd_if.sink    cmd_in,
    hdrc_res_if.source  res_out,
    input  logic        wr_en,
    input  logic [0:0]  wr_index,
    input  logic [31:0] wr_data
);
    import hdrc_pkg::*;

    logic [31:0] attach_reg;
    logic [31:0] detach_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // timeout registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attach_reg <= '0;
            detach_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_ATTACH: attach_reg <= wr_data;
                CFG_DETACH: detach_reg <= wr_data;
                default: ;
            endcase
        end
    end

    hdrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_in.valid),
        .in_ready (cmd_in.ready),
        .in_mode  (cmd_in.data.mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    hdrc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (cmd_in.data),
        .attach_timeout (attach_reg),
        .detach_timeout (detach_reg),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (res_out.valid),
        .out_ready      (res_out.ready),
        .out_data       (res_out.data)
    );

    // status words carry no action or sequence
    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.data.last |-> res_out.data.action == AC_REQUESTED
        && res_out.data.sequence_res == 8'd0)
        else $error("status word with record fields");

    // no new command while a record is pending; a pending status word does not block it
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |-> !cmd_in.ready || res_out.data.last)
        else $error("accepting during stall");

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.data))
        else $error("result changed under stall");

endmodule
